FILE: rtl/core/bcr_pkg.sv
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared widths, codes, state type and link structs for the bicubic resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bcr_pkg;

  localparam int PIX_W      = 8;
  localparam int ADDR_W     = 18;
  localparam int STORE_DEPTH = 2 ** ADDR_W;
  localparam int POS_W      = 16;
  localparam int FRAC_BITS  = 8;
  localparam int INT_W      = POS_W - FRAC_BITS;
  localparam int CH_W       = 2;
  localparam int DIM_W      = 9;
  localparam int CCNT_W     = 3;
  localparam int PAR_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // kernel arithmetic
  localparam int T_W      = FRAC_BITS + 2;
  localparam int COEF_W   = 17;
  localparam int P1_W     = 30;
  localparam int P2_W     = 42;
  localparam int P3_W     = 54;
  localparam int M_W      = 32;
  localparam int DIV_SH   = 3 * FRAC_BITS - 5;
  localparam int WGT_W    = 24;
  localparam int QMAG_W   = WGT_W - 1;
  localparam int TAG_W    = 3;

  // tap datapath
  localparam int WPROD_W  = 2 * WGT_W;
  localparam int PROD_W   = WPROD_W + PIX_W;
  localparam int ACC_W    = PROD_W + 4;
  localparam int OUT_SH   = 28;

  // sequencer counts
  localparam int CNT_W        = 5;
  localparam int KER_ISSUES   = 8;
  localparam int KER_LAST     = 12;
  localparam int TAP_LAST     = 15;
  localparam int DRAIN_LAST   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_C        = 3'd4;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WEIGHT,
    ST_TAPS,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [T_W-1:0]   t;
  } kreq_t;

  typedef struct packed {
    logic                    valid;
    logic [TAG_W-1:0]        tag;
    logic signed [WGT_W-1:0] weight;
  } kres_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } st_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/bcr_if.sv
// ----------------------------------------------------------------------------
// bcr_if
// Handshake channels of the resampler: input words, results, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [bcr_pkg::ADDR_W-1:0]   pixel_index;
  logic [bcr_pkg::PIX_W-1:0]    pixel_value;
  logic [bcr_pkg::POS_W-1:0]    sample_x;
  logic [bcr_pkg::POS_W-1:0]    sample_y;
  logic [bcr_pkg::CH_W-1:0]     channel;
  modport source (output valid, action, pixel_index, pixel_value, sample_x, sample_y,
                  channel, input ready);
  modport sink (input valid, action, pixel_index, pixel_value, sample_x, sample_y,
                channel, output ready);
endinterface

interface bcr_out_if;
  logic                      valid;
  logic                      ready;
  logic [bcr_pkg::PIX_W-1:0] sample_value;
  modport source (output valid, sample_value, input ready);
  modport sink (input valid, sample_value, output ready);
endinterface

interface bcr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bcr_pkg::CFG_IDX_W-1:0]  index;
  logic [bcr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bcr_store.sv
// ----------------------------------------------------------------------------
// bcr_store
// Single-port image store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_store (
  input  wire logic                      clk,
  input  wire bcr_pkg::st_req_t          req,
  output logic [bcr_pkg::PIX_W-1:0]      rdata
);

  logic [bcr_pkg::PIX_W-1:0] mem [bcr_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bcr_kernel.sv
// ----------------------------------------------------------------------------
// bcr_kernel
// Pipelined B,C cubic kernel: Horner evaluation, rounding to Q2.14.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_kernel (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bcr_pkg::kreq_t              req,
  input  wire logic [bcr_pkg::PAR_W-1:0]   b_param,
  input  wire logic [bcr_pkg::PAR_W-1:0]   c_param,
  output bcr_pkg::kres_t                   res
);

  localparam int CW = bcr_pkg::COEF_W;
  localparam int F  = bcr_pkg::FRAC_BITS;

  logic signed [CW-1:0] b_s, c_s;
  logic signed [CW-1:0] a3, a2, a1, a0;
  logic                 near, far;
  logic signed [bcr_pkg::T_W:0] t0_s, t1_s, t2_s;

  logic                          v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [bcr_pkg::TAG_W-1:0]     tag1_r, tag2_r, tag3_r, tag4_r, tag5_r;
  logic                          z1_r, z2_r, z3_r, z4_r;
  logic                          neg4_r;
  logic [bcr_pkg::T_W-1:0]       t1_r, t2_r;
  logic signed [CW-1:0]          a1_1_r, a0_1_r, a0_2_r;
  logic signed [bcr_pkg::P1_W-1:0] p1_nxt, p1_r;
  logic signed [bcr_pkg::P2_W-1:0] p2_nxt, p2_r;
  logic signed [bcr_pkg::P3_W-1:0] p3_nxt, p3_r;
  logic [bcr_pkg::P3_W-1:0]      mag;
  logic [bcr_pkg::P3_W:0]        msum;
  logic [bcr_pkg::M_W-1:0]       m_nxt, m_r;
  logic [2*bcr_pkg::M_W-1:0]     q64;
  logic [bcr_pkg::QMAG_W-1:0]    qmag;
  logic signed [bcr_pkg::WGT_W-1:0] w_nxt, w_r;

  // piece select and coefficients, b and c in units of 1/256
  always_comb begin
    b_s  = signed'(CW'(b_param));
    c_s  = signed'(CW'(c_param));
    near = (req.t[bcr_pkg::T_W-1:F] == 2'b00);
    far  = (req.t[bcr_pkg::T_W-1:F] == 2'b01);
    if (near) begin
      a3 = 17'sd3072 - 17'sd9 * b_s - 17'sd6 * c_s;
      a2 = -17'sd4608 + 17'sd12 * b_s + 17'sd6 * c_s;
      a1 = '0;
      a0 = 17'sd1536 - 17'sd2 * b_s;
    end else begin
      a3 = -b_s - 17'sd6 * c_s;
      a2 = 17'sd6 * b_s + 17'sd30 * c_s;
      a1 = -17'sd12 * b_s - 17'sd48 * c_s;
      a0 = 17'sd8 * b_s + 17'sd24 * c_s;
    end
    t0_s   = signed'({1'b0, req.t});
    p1_nxt = a3 * t0_s + (bcr_pkg::P1_W'(a2) <<< F);
  end

  always_comb begin
    t1_s   = signed'({1'b0, t1_r});
    p2_nxt = p1_r * t1_s + (bcr_pkg::P2_W'(a1_1_r) <<< (2 * F));
    t2_s   = signed'({1'b0, t2_r});
    p3_nxt = p2_r * t2_s + (bcr_pkg::P3_W'(a0_2_r) <<< (3 * F));
  end

  // divide by 6*s^3/64 with rounding: shift, then exact divide by three
  always_comb begin
    mag   = p3_r[bcr_pkg::P3_W-1] ? unsigned'(-p3_r) : unsigned'(p3_r);
    msum  = {1'b0, mag} + ((bcr_pkg::P3_W+1)'(3) << (3 * F - 6));
    m_nxt = msum[bcr_pkg::DIV_SH + bcr_pkg::M_W - 1 : bcr_pkg::DIV_SH];
    q64   = m_r * 64'h0000_0000_AAAA_AAAB;
    qmag  = q64[33 + bcr_pkg::QMAG_W - 1 : 33];
    if (z4_r) begin
      w_nxt = '0;
    end else if (neg4_r) begin
      w_nxt = -signed'({1'b0, qmag});
    end else begin
      w_nxt = signed'({1'b0, qmag});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= req.tag;
    z1_r   <= !(near || far);
    t1_r   <= req.t;
    p1_r   <= p1_nxt;
    a1_1_r <= a1;
    a0_1_r <= a0;
    tag2_r <= tag1_r;
    z2_r   <= z1_r;
    t2_r   <= t1_r;
    p2_r   <= p2_nxt;
    a0_2_r <= a0_1_r;
    tag3_r <= tag2_r;
    z3_r   <= z2_r;
    p3_r   <= p3_nxt;
    tag4_r <= tag3_r;
    z4_r   <= z3_r;
    neg4_r <= p3_r[bcr_pkg::P3_W-1];
    m_r    <= m_nxt;
    tag5_r <= tag4_r;
    w_r    <= w_nxt;
  end

  assign res.valid  = v5_r;
  assign res.tag    = tag5_r;
  assign res.weight = w_r;

endmodule

`default_nettype wire

FILE: rtl/core/bc_spline_image_resampler_core.sv
// ----------------------------------------------------------------------------
// bc_spline_image_resampler_core
// Mitchell-Netravali bicubic sampler over an interleaved 8-bit image store.
// ----------------------------------------------------------------------------
//  port     dir  handshake      carries
//  in_ch    in   valid/ready    action, pixel_index, pixel_value, sample_x/y, channel
//  out_ch   out  valid/ready    sample_value
//  cfg_ch   in   valid/ready    index, data (ready always high)
//
//  a write word is written to the store as it is accepted; a sample word computes
//  the eight kernel weights, then makes 16 store reads (one per cycle on the
//  single store port), drains the multiply-accumulate and loads the output
//  a finished result waits in the output register; the next word is taken
//  meanwhile, a new sample only stalls at its end while that register is full
//  reset is synchronous; the store is not cleared
`default_nettype none

module bc_spline_image_resampler_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bcr_in_if.sink     in_ch,
  bcr_out_if.source  out_ch,
  bcr_cfg_if.sink    cfg_ch
);

  localparam int CNT_W = bcr_pkg::CNT_W;

  bcr_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [bcr_pkg::DIM_W-1:0]  w_r, h_r;
  logic [bcr_pkg::CCNT_W-1:0] cc_r;
  logic [bcr_pkg::PAR_W-1:0]  b_r, c_r;

  logic [bcr_pkg::FRAC_BITS-1:0] fx_r, fy_r;
  logic [bcr_pkg::INT_W-1:0]     ix_r, iy_r;
  logic [bcr_pkg::CH_W-1:0]      ch_r;

  logic in_acc, start, wr_go, done_go, ker_go, tap_go;

  bcr_pkg::kreq_t  ker_req;
  bcr_pkg::kres_t  ker_res;
  bcr_pkg::st_req_t st_req;
  logic [bcr_pkg::PIX_W-1:0] rdata;

  logic signed [bcr_pkg::WGT_W-1:0] wx_r [4];
  logic signed [bcr_pkg::WGT_W-1:0] wy_r [4];

  logic [bcr_pkg::FRAC_BITS-1:0] kf;
  logic [1:0] ti, tj;
  logic signed [bcr_pkg::DIM_W:0] row, col;
  logic in_bounds;
  logic [bcr_pkg::ADDR_W-1:0] rowmul, lin_nxt, rd_addr;

  logic go1_r, v1_r, v2_r, v3_r;
  logic [1:0] i1_r, j1_r;
  logic [bcr_pkg::ADDR_W-1:0] lin_r;
  logic signed [bcr_pkg::WPROD_W-1:0] wprod_r;
  logic signed [bcr_pkg::PROD_W-1:0]  prod_r;
  logic signed [bcr_pkg::ACC_W-1:0]   acc_r;

  logic [bcr_pkg::ACC_W-1:0] amag, arnd;
  logic [bcr_pkg::ACC_W-bcr_pkg::OUT_SH-1:0] ares;
  logic [bcr_pkg::PIX_W-1:0] sat;

  logic out_valid_r;
  logic [bcr_pkg::PIX_W-1:0] out_value_r;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign start  = in_acc && (in_ch.action == bcr_pkg::ACT_SAMPLE);
  assign wr_go  = in_acc && (in_ch.action == bcr_pkg::ACT_WRITE);

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= 9'd256;
      h_r  <= 9'd256;
      cc_r <= 3'd1;
      b_r  <= 9'd0;
      c_r  <= 9'd128;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bcr_pkg::CFG_WIDTH:    w_r  <= cfg_ch.data;
        bcr_pkg::CFG_HEIGHT:   h_r  <= cfg_ch.data;
        bcr_pkg::CFG_CHANNELS: cc_r <= cfg_ch.data[bcr_pkg::CCNT_W-1:0];
        bcr_pkg::CFG_B:        b_r  <= cfg_ch.data;
        bcr_pkg::CFG_C:        c_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CNT_W'(1);
    unique case (state_r)
      bcr_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = bcr_pkg::ST_WEIGHT;
        end
      end
      bcr_pkg::ST_WEIGHT: begin
        if (cnt_r == CNT_W'(bcr_pkg::KER_LAST)) begin
          state_nxt = bcr_pkg::ST_TAPS;
          cnt_nxt   = '0;
        end
      end
      bcr_pkg::ST_TAPS: begin
        if (cnt_r == CNT_W'(bcr_pkg::TAP_LAST)) begin
          state_nxt = bcr_pkg::ST_DRAIN;
          cnt_nxt   = '0;
        end
      end
      bcr_pkg::ST_DRAIN: begin
        if (cnt_r == CNT_W'(bcr_pkg::DRAIN_LAST)) begin
          state_nxt = bcr_pkg::ST_DONE;
          cnt_nxt   = '0;
        end
      end
      bcr_pkg::ST_DONE: begin
        cnt_nxt = '0;
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = bcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bcr_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    ker_go      = 1'b0;
    tap_go      = 1'b0;
    done_go     = 1'b0;
    unique case (state_r)
      bcr_pkg::ST_IDLE:   in_ch.ready = 1'b1;
      bcr_pkg::ST_WEIGHT: ker_go = (cnt_r < CNT_W'(bcr_pkg::KER_ISSUES));
      bcr_pkg::ST_TAPS:   tap_go = 1'b1;
      bcr_pkg::ST_DRAIN:  ;
      bcr_pkg::ST_DONE:   done_go = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcr_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      fx_r <= in_ch.sample_x[bcr_pkg::FRAC_BITS-1:0];
      fy_r <= in_ch.sample_y[bcr_pkg::FRAC_BITS-1:0];
      ix_r <= in_ch.sample_x[bcr_pkg::POS_W-1:bcr_pkg::FRAC_BITS];
      iy_r <= in_ch.sample_y[bcr_pkg::POS_W-1:bcr_pkg::FRAC_BITS];
      ch_r <= in_ch.channel;
    end
  end

  // kernel requests: tags 0..3 are x taps, 4..7 are y taps
  always_comb begin
    kf = cnt_r[2] ? fy_r : fx_r;
    unique case (cnt_r[1:0])
      2'd0: ker_req.t = bcr_pkg::T_W'(1 << bcr_pkg::FRAC_BITS) + bcr_pkg::T_W'(kf);
      2'd1: ker_req.t = bcr_pkg::T_W'(kf);
      2'd2: ker_req.t = bcr_pkg::T_W'(1 << bcr_pkg::FRAC_BITS) - bcr_pkg::T_W'(kf);
      2'd3: ker_req.t = bcr_pkg::T_W'(2 << bcr_pkg::FRAC_BITS) - bcr_pkg::T_W'(kf);
      default: ker_req.t = '0;
    endcase
    ker_req.valid = ker_go;
    ker_req.tag   = cnt_r[bcr_pkg::TAG_W-1:0];
  end

  bcr_kernel u_kernel (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ker_req),
    .b_param (b_r),
    .c_param (c_r),
    .res     (ker_res)
  );

  always_ff @(posedge clk) begin
    if (ker_res.valid) begin
      if (ker_res.tag[2]) begin
        wy_r[ker_res.tag[1:0]] <= ker_res.weight;
      end else begin
        wx_r[ker_res.tag[1:0]] <= ker_res.weight;
      end
    end
  end

  // tap address: bounds check and row-major linear index
  always_comb begin
    ti      = cnt_r[1:0];
    tj      = cnt_r[3:2];
    row     = signed'((bcr_pkg::DIM_W+1)'(iy_r) + (bcr_pkg::DIM_W+1)'(tj)) - 10'sd1;
    col     = signed'((bcr_pkg::DIM_W+1)'(ix_r) + (bcr_pkg::DIM_W+1)'(ti)) - 10'sd1;
    in_bounds = !row[bcr_pkg::DIM_W] && (row[bcr_pkg::DIM_W-1:0] < h_r) &&
                !col[bcr_pkg::DIM_W] && (col[bcr_pkg::DIM_W-1:0] < w_r);
    rowmul  = row[bcr_pkg::DIM_W-1:0] * w_r;
    lin_nxt = rowmul + bcr_pkg::ADDR_W'(col[bcr_pkg::DIM_W-1:0]);
    rd_addr = lin_r * bcr_pkg::ADDR_W'(cc_r) + bcr_pkg::ADDR_W'(ch_r);
  end

  always_comb begin
    st_req.en    = wr_go || go1_r;
    st_req.we    = wr_go;
    st_req.addr  = wr_go ? in_ch.pixel_index : rd_addr;
    st_req.wdata = in_ch.pixel_value;
  end

  bcr_store u_store (
    .clk   (clk),
    .req   (st_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go1_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      go1_r <= tap_go;
      v1_r  <= tap_go && in_bounds;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    lin_r   <= lin_nxt;
    i1_r    <= ti;
    j1_r    <= tj;
    wprod_r <= wx_r[i1_r] * wy_r[j1_r];
    prod_r  <= signed'({1'b0, rdata}) * wprod_r;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + bcr_pkg::ACC_W'(prod_r);
    end
  end

  // round half up on the magnitude, saturate at full scale
  always_comb begin
    amag = acc_r[bcr_pkg::ACC_W-1] ? unsigned'(-acc_r) : unsigned'(acc_r);
    arnd = amag + (bcr_pkg::ACC_W'(1) << (bcr_pkg::OUT_SH - 1));
    ares = arnd[bcr_pkg::ACC_W-1:bcr_pkg::OUT_SH];
    sat  = (ares > (bcr_pkg::ACC_W-bcr_pkg::OUT_SH)'(255)) ? 8'd255 : ares[bcr_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_value_r <= sat;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_value = out_value_r;

  a_ker_in_weight: assert property (@(posedge clk) disable iff (!rst_n)
    ker_res.valid |-> state_r == bcr_pkg::ST_WEIGHT)
    else $error("kernel result outside weight phase");

  a_read_in_taps: assert property (@(posedge clk) disable iff (!rst_n)
    (st_req.en && !st_req.we) |-> (state_r == bcr_pkg::ST_TAPS ||
                                   state_r == bcr_pkg::ST_DRAIN))
    else $error("store read outside tap phase");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (state_r == bcr_pkg::ST_WEIGHT && acc_r == '0))
    else $error("sample start did not clear accumulator");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    done_go |=> (out_valid_r && state_r == bcr_pkg::ST_IDLE))
    else $error("finished sample not loaded into output register");

endmodule

`default_nettype wire

FILE: test/tb_bc_spline_image_resampler_core.sv
// ----------------------------------------------------------------------------
// tb_bc_spline_image_resampler_core
// Self-checking bench for the bicubic resampler. Loads pixels, samples them
// under several spline and image settings, and checks every result against a
// bit-exact integer model of the kernel and the 4x4 tap sum, or a given value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_bc_spline_image_resampler_core;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 45;

  typedef struct {
    logic                         act;
    logic [bcr_pkg::ADDR_W-1:0]   idx;
    logic [bcr_pkg::PIX_W-1:0]    pix;
    logic [bcr_pkg::POS_W-1:0]    x;
    logic [bcr_pkg::POS_W-1:0]    y;
    logic [bcr_pkg::CH_W-1:0]     ch;
    bit                           has_val;
    logic [bcr_pkg::PIX_W-1:0]    val;
  } word_t;

  logic clk;
  logic rst_n;

  bcr_in_if  in_ch();
  bcr_out_if out_ch();
  bcr_cfg_if cfg_ch();

  bc_spline_image_resampler_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // model state
  logic [bcr_pkg::PIX_W-1:0]  pix_mem [bcr_pkg::STORE_DEPTH];
  bit                         pix_set [bcr_pkg::STORE_DEPTH];
  logic [bcr_pkg::DIM_W-1:0]  img_w, img_h;
  logic [bcr_pkg::CCNT_W-1:0] img_cc;
  logic [bcr_pkg::PAR_W-1:0]  spl_b, spl_c;

  logic [bcr_pkg::PIX_W-1:0] pending_vals[$];
  word_t            directed[$];
  int  mismatches, results_seen, samples_sent, writes_sent, cycles;
  bit  idling_on, hold_off_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_vals.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // cubic weight in Q2.14 at distance t (Q8)
  function automatic longint spline_weight(longint t);
    longint b, c, s, a3, a2, a1, a0, n, den, mag;
    b = spl_b; c = spl_c; s = 256;
    if (t < s) begin
      a3 = 12*256 - 9*b - 6*c; a2 = -18*256 + 12*b + 6*c; a1 = 0; a0 = 6*256 - 2*b;
    end else if (t < 2*s) begin
      a3 = -b - 6*c; a2 = 6*b + 30*c; a1 = -12*b - 48*c; a0 = 8*b + 24*c;
    end else begin
      return 0;
    end
    n = (a3*t*t*t + a2*t*t*s + a1*t*s*s + a0*s*s*s) * 64;
    den = 6*s*s*s;
    mag = n < 0 ? -n : n;
    mag = (mag + den/2) / den;
    return n < 0 ? -mag : mag;
  endfunction

  // address of tap (i,j), or -1 when skipped
  function automatic longint tap_addr(logic [bcr_pkg::POS_W-1:0] x,
                                      logic [bcr_pkg::POS_W-1:0] y,
                                      logic [bcr_pkg::CH_W-1:0] ch, int i, int j);
    longint row, col, a;
    row = longint'(y >> bcr_pkg::FRAC_BITS) + j - 1;
    col = longint'(x >> bcr_pkg::FRAC_BITS) + i - 1;
    if (row < 0 || row >= img_h || col < 0 || col >= img_w) return -1;
    a = ((row * img_w + col) * img_cc + ch) % bcr_pkg::STORE_DEPTH;
    return a;
  endfunction

  function automatic bit taps_written(logic [bcr_pkg::POS_W-1:0] x,
                                      logic [bcr_pkg::POS_W-1:0] y,
                                      logic [bcr_pkg::CH_W-1:0] ch);
    longint a;
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++) begin
        a = tap_addr(x, y, ch, i, j);
        if (a >= 0 && !pix_set[a]) return 0;
      end
    return 1;
  endfunction

  function automatic logic [bcr_pkg::PIX_W-1:0] bicubic_value(
      logic [bcr_pkg::POS_W-1:0] x, logic [bcr_pkg::POS_W-1:0] y,
      logic [bcr_pkg::CH_W-1:0] ch);
    longint wx[4], wy[4], d, a, acc, mag;
    acc = 0;
    for (int i = 0; i < 4; i++) begin
      d = longint'(i - 1) * 256 - longint'(x[bcr_pkg::FRAC_BITS-1:0]);
      wx[i] = spline_weight(d < 0 ? -d : d);
      d = longint'(i - 1) * 256 - longint'(y[bcr_pkg::FRAC_BITS-1:0]);
      wy[i] = spline_weight(d < 0 ? -d : d);
    end
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++) begin
        a = tap_addr(x, y, ch, i, j);
        if (a >= 0) acc += longint'(pix_mem[a]) * wx[i] * wy[j];
      end
    mag = acc < 0 ? -acc : acc;
    mag = (mag + (longint'(1) << 27)) >>> 28;
    if (mag > 255) mag = 255;
    return mag[bcr_pkg::PIX_W-1:0];
  endfunction

  task automatic send_word(input word_t w);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = w.act;
    in_ch.pixel_index = w.idx;
    in_ch.pixel_value = w.pix;
    in_ch.sample_x = w.x;
    in_ch.sample_y = w.y;
    in_ch.channel = w.ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (w.act == bcr_pkg::ACT_WRITE) begin
      pix_mem[w.idx] = w.pix;
      pix_set[w.idx] = 1'b1;
      writes_sent++;
    end else begin
      pending_vals.push_back(w.has_val ? w.val : bicubic_value(w.x, w.y, w.ch));
      samples_sent++;
    end
    @(negedge clk);
  endtask

  // called at a falling edge, right after the last word went out
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending_vals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [bcr_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val[bcr_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      bcr_pkg::CFG_WIDTH:    img_w = val[bcr_pkg::DIM_W-1:0];
      bcr_pkg::CFG_HEIGHT:   img_h = val[bcr_pkg::DIM_W-1:0];
      bcr_pkg::CFG_CHANNELS: img_cc = val[bcr_pkg::CCNT_W-1:0];
      bcr_pkg::CFG_B:        spl_b = val[bcr_pkg::PAR_W-1:0];
      bcr_pkg::CFG_C:        spl_c = val[bcr_pkg::PAR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic word_t pix_word(int idx, int v);
    word_t w;
    w = '{act: bcr_pkg::ACT_WRITE, idx: idx[bcr_pkg::ADDR_W-1:0],
          pix: v[bcr_pkg::PIX_W-1:0], x: bcr_pkg::POS_W'($urandom),
          y: bcr_pkg::POS_W'($urandom), ch: bcr_pkg::CH_W'($urandom),
          has_val: 1'b0, val: '0};
    return w;
  endfunction

  function automatic word_t sample_word(int x, int y, int ch, bit known, int v);
    word_t w;
    w = '{act: bcr_pkg::ACT_SAMPLE, idx: bcr_pkg::ADDR_W'($urandom),
          pix: bcr_pkg::PIX_W'($urandom), x: x[bcr_pkg::POS_W-1:0],
          y: y[bcr_pkg::POS_W-1:0], ch: ch[bcr_pkg::CH_W-1:0], has_val: known,
          val: v[bcr_pkg::PIX_W-1:0]};
    return w;
  endfunction

  // load a corner window of the image, all four channel slots
  task automatic load_corner();
    int rows, cols;
    longint a;
    rows = img_h < 5 ? int'(img_h) : 5;
    cols = img_w < 5 ? int'(img_w) : 5;
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        for (int k = 0; k < 4; k++) begin
          a = ((longint'(r) * img_w + c) * img_cc + k) % bcr_pkg::STORE_DEPTH;
          send_word(pix_word(int'(a), $urandom_range(0, 5) == 0 ?
                                      255 * $urandom_range(0, 1) : $urandom_range(0, 255)));
        end
  endtask

  task automatic random_words(int n);
    word_t w;
    int xi, yi, tries;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        w = pix_word(int'($urandom), int'($urandom));
      end else begin
        tries = 0;
        do begin
          if ($urandom_range(0, 3) != 0) begin
            xi = $urandom_range(0, img_w < 5 ? int'(img_w) : 5);
            yi = $urandom_range(0, img_h < 5 ? int'(img_h) : 5);
            w = sample_word(xi * 256 + $urandom_range(0, 255),
                            yi * 256 + $urandom_range(0, 255), int'($urandom), 0, 0);
          end else begin
            w = sample_word(int'($urandom), int'($urandom), int'($urandom), 0, 0);
          end
          tries++;
        end while (!taps_written(w.x, w.y, w.ch) && tries < 30);
        if (!taps_written(w.x, w.y, w.ch)) w = pix_word(int'($urandom), int'($urandom));
      end
      send_word(w);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = 600;
      end else if (stall == 0 && idling_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11);
      end
      out_ch.ready = (stall == 0);
      if (stall > 0) stall--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_vals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %0d", out_ch.sample_value);
      end else begin
        if (out_ch.sample_value !== pending_vals[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample_value mismatch: expected %0d, got %0d",
                     pending_vals[0], out_ch.sample_value);
        end
        void'(pending_vals.pop_front());
      end
    end
  end

  initial begin
    int phase_cfg[10][5];
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    samples_sent = 0;
    writes_sent = 0;
    idling_on = 1'b1;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = bcr_pkg::ACT_WRITE;
    in_ch.pixel_index = '0;
    in_ch.pixel_value = '0;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    in_ch.channel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = bcr_pkg::CFG_WIDTH;
    cfg_ch.data = '0;
    img_w = 9'd256; img_h = 9'd256; img_cc = 3'd1; spl_b = 9'd0; spl_c = 9'd128;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part under reset settings (Catmull-Rom: integer positions copy the pixel)
    directed.push_back(pix_word(0, 255));
    directed.push_back(pix_word(1, 0));
    directed.push_back(pix_word(2, 255));
    directed.push_back(pix_word(256, 0));
    directed.push_back(pix_word(257, 255));
    directed.push_back(pix_word(258, 0));
    directed.push_back(pix_word(512, 255));
    directed.push_back(pix_word(513, 0));
    directed.push_back(pix_word(514, 255));
    directed.push_back(sample_word(0, 0, 0, 1, 255));
    directed.push_back(sample_word('h0080, 'h0080, 0, 0, 0));
    directed.push_back(sample_word('h0040, 'h00c0, 0, 0, 0));
    directed.push_back(pix_word(65278, 255));
    directed.push_back(pix_word(65279, 255));
    directed.push_back(pix_word(65534, 255));
    directed.push_back(pix_word(65535, 255));
    directed.push_back(sample_word('hff00, 'hff00, 0, 1, 255));
    directed.push_back(sample_word('hffff, 'hffff, 0, 0, 0));
    directed.push_back(pix_word(bcr_pkg::STORE_DEPTH - 1, 0));
    directed.push_back(pix_word('h2aaaa, 'haa));
    directed.push_back(pix_word('h15555, 'h55));
    foreach (directed[k]) send_word(directed[k]);
    wait_idle();

    phase_cfg = '{'{1, 1, 1, 0, 0}, '{256, 256, 4, 256, 256}, '{7, 5, 3, 85, 85},
                  '{0, 511, 7, 511, 511}, '{16, 12, 2, 64, 200}, '{511, 3, 0, 256, 0},
                  '{3, 256, 4, 0, 128}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0},
                  '{0, 0, 0, 0, 0}};
    for (int p = 7; p < 10; p++) begin
      phase_cfg[p][0] = $urandom_range(1, 256);
      phase_cfg[p][1] = $urandom_range(1, 256);
      phase_cfg[p][2] = $urandom_range(1, 4);
      phase_cfg[p][3] = $urandom_range(0, 256);
      phase_cfg[p][4] = $urandom_range(0, 256);
    end

    for (int p = 0; p < 10; p++) begin
      write_reg(bcr_pkg::CFG_WIDTH, phase_cfg[p][0]);
      write_reg(bcr_pkg::CFG_HEIGHT, phase_cfg[p][1]);
      write_reg(bcr_pkg::CFG_CHANNELS, phase_cfg[p][2]);
      write_reg(bcr_pkg::CFG_B, phase_cfg[p][3]);
      write_reg(bcr_pkg::CFG_C, phase_cfg[p][4]);
      if (p >= 8) idling_on = 1'b0;
      load_corner();
      if (p == 1) hold_off_req = 1'b1;
      random_words(110);
      wait_idle();
    end

    $display("covered %0d pixel writes and %0d samples over 11 register settings",
             writes_sent, samples_sent);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending_vals.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
